### rtl/flspq_pkg.sv
`timescale 1ns / 1ps

package flspq_pkg;

	// input opcodes
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_POP    = 1'b1
	} opcode_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FULL    = 2'd2,
		ST_BADPRIO = 2'd3
	} status_t;

	localparam int TAG_W = 16;
	localparam int PRIO_W = 3;
	localparam int OCC_W = 7;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_DONE = 2'd2
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic latch_in;
		logic exec;
		logic load_out;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

### rtl/five_level_stable_priority_queue.sv
`timescale 1ns / 1ps

// five-level stable priority queue: inserts a 16-bit tag at priority 1..LEVELS
// (LEVELS most urgent) and pops the oldest tag of the most urgent non-empty
// level, each level a fifo ring of LEVEL_DEPTH entries held in one shared
// single-port tag ram. every input transaction gives exactly one output
// transaction carrying status (ok, empty, level full, bad priority) and the
// total occupancy after the item. items are handled one at a time: an item
// passes through accept, execute with the ram access and load of the output
// register, and the load waits while a stalled result still holds the output
// register, so a new item is accepted only after the previous result has been
// loaded. the controller's accept/execute/load sequence is built around the
// ram's registered read port. the output register parts the two sides, so
// a new item is taken while the previous result is still waiting. the tag ram
// needs no clearing after reset; only entries that were written are ever read.

module five_level_stable_priority_queue import flspq_pkg::*; #(
	parameter int LEVELS = 5,
	parameter int LEVEL_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              opcode,
	input  logic [PRIO_W-1:0] entry_priority,
	input  logic [TAG_W-1:0]  entry_tag,
	// output channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [TAG_W-1:0]  served_tag,
	output logic [PRIO_W-1:0] served_priority,
	output logic [1:0]        status,
	output logic [OCC_W-1:0]  occupancy
);

	// command and status between controller and datapath
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer: idle (accept), execute, load result
	flspq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat    (stat),
		.cmd     (cmd)
	);

	// level rings, priority encoder, tag ram and output register
	flspq_dp #(
		.LEVELS     (LEVELS),
		.LEVEL_DEPTH(LEVEL_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.opcode         (opcode),
		.entry_priority (entry_priority),
		.entry_tag      (entry_tag),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.served_tag     (served_tag),
		.served_priority(served_priority),
		.status         (status),
		.occupancy      (occupancy)
	);

endmodule

### rtl/flspq_ram.sv
`timescale 1ns / 1ps

module flspq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 80
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/flspq_ctrl.sv
`timescale 1ns / 1ps

module flspq_ctrl import flspq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.latch_in = in_valid;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
			end
			S_DONE: begin
				cmd.load_out = stat.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

### rtl/flspq_dp.sv
`timescale 1ns / 1ps

module flspq_dp import flspq_pkg::*; #(
	parameter int LEVELS = 5,
	parameter int LEVEL_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_stat_t          stat,
	input  logic              opcode,
	input  logic [PRIO_W-1:0] entry_priority,
	input  logic [TAG_W-1:0]  entry_tag,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [TAG_W-1:0]  served_tag,
	output logic [PRIO_W-1:0] served_priority,
	output logic [1:0]        status,
	output logic [OCC_W-1:0]  occupancy
);

	localparam int LW = $clog2(LEVELS);
	localparam int PW = $clog2(LEVEL_DEPTH);
	localparam int CW = $clog2(LEVEL_DEPTH + 1);
	localparam int ND = LEVELS * LEVEL_DEPTH;
	localparam int AW = $clog2(ND);
	localparam int TW = $clog2(ND + 1);

	// latched item
	logic              op_q;
	logic [PRIO_W-1:0] prio_q;
	logic [TAG_W-1:0]  tag_q;

	// per-level ring state
	logic [PW-1:0] head_q  [0:LEVELS-1];
	logic [PW-1:0] tail_q  [0:LEVELS-1];
	logic [CW-1:0] count_q [0:LEVELS-1];
	logic [TW-1:0] total_q;

	// pending result
	logic              res_pop_q;
	logic [PRIO_W-1:0] res_prio_q;
	status_t           res_status_q;

	// output register
	logic              out_valid_q;
	logic [TAG_W-1:0]  served_tag_q;
	logic [PRIO_W-1:0] served_prio_q;
	logic [1:0]        status_q;
	logic [OCC_W-1:0]  occ_q;

	logic          bad_prio;
	logic [LW-1:0] ins_lv;
	logic [LW-1:0] pop_lv;
	logic          any_held;
	logic [LW-1:0] sel_lv;
	logic [PW-1:0] sel_head;
	logic [PW-1:0] sel_tail;
	logic [CW-1:0] sel_count;
	logic          lvl_full;
	logic          do_ins;
	logic          do_pop;
	logic [PW-1:0] sel_ptr;
	logic [PW-1:0] ptr_next;
	logic [AW-1:0] ram_addr;
	logic [TAG_W-1:0] ram_rdata;

	// insert level check
	always_comb begin
		bad_prio = (prio_q == '0) || (int'(prio_q) > LEVELS);
		ins_lv = bad_prio ? '0 : LW'(prio_q - PRIO_W'(1));
	end

	// highest non-empty level
	always_comb begin
		pop_lv = '0;
		any_held = 1'b0;
		for (int i = 0; i < LEVELS; i++) begin
			if (count_q[i] != '0) begin
				pop_lv = LW'(i);
				any_held = 1'b1;
			end
		end
	end

	assign sel_lv = (op_q == OP_POP) ? pop_lv : ins_lv;
	assign sel_head = head_q[sel_lv];
	assign sel_tail = tail_q[sel_lv];
	assign sel_count = count_q[sel_lv];
	assign lvl_full = (sel_count == CW'(LEVEL_DEPTH));

	assign do_ins = cmd.exec && (op_q == OP_INSERT) && !bad_prio && !lvl_full;
	assign do_pop = cmd.exec && (op_q == OP_POP) && any_held;

	assign sel_ptr = (op_q == OP_POP) ? sel_head : sel_tail;
	assign ptr_next = (sel_ptr == PW'(LEVEL_DEPTH - 1)) ? '0 : sel_ptr + PW'(1);
	assign ram_addr = AW'(32'(sel_lv) * LEVEL_DEPTH + 32'(sel_ptr));

	flspq_ram #(
		.WIDTH(TAG_W),
		.DEPTH(ND)
	) u_tag_ram (
		.clk  (clk),
		.we   (do_ins),
		.re   (do_pop),
		.addr (ram_addr),
		.wdata(tag_q),
		.rdata(ram_rdata)
	);

	// item, pending result and output register data, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q <= opcode;
			prio_q <= entry_priority;
			tag_q <= entry_tag;
		end
		if (cmd.exec) begin
			res_pop_q <= do_pop;
			res_prio_q <= '0;
			res_status_q <= ST_OK;
			if (op_q == OP_INSERT) begin
				if (bad_prio) begin
					res_status_q <= ST_BADPRIO;
				end else if (lvl_full) begin
					res_status_q <= ST_FULL;
				end
			end else begin
				if (!any_held) begin
					res_status_q <= ST_EMPTY;
				end else begin
					res_prio_q <= PRIO_W'({1'b0, pop_lv} + (LW + 1)'(1));
				end
			end
		end
		if (cmd.load_out) begin
			served_tag_q <= res_pop_q ? ram_rdata : '0;
			served_prio_q <= res_prio_q;
			status_q <= res_status_q;
			occ_q <= OCC_W'(total_q);
		end
	end

	// ring pointers, counts and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				count_q[i] <= '0;
			end
			total_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_ins) begin
				tail_q[sel_lv] <= ptr_next;
				count_q[sel_lv] <= sel_count + CW'(1);
				total_q <= total_q + TW'(1);
			end
			if (do_pop) begin
				head_q[sel_lv] <= ptr_next;
				count_q[sel_lv] <= sel_count - CW'(1);
				total_q <= total_q - TW'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign served_tag = served_tag_q;
	assign served_priority = served_prio_q;
	assign status = status_q;
	assign occupancy = occ_q;

endmodule

### rtl/flspq_checker.sv
`timescale 1ns / 1ps

module flspq_checker import flspq_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              opcode,
	input logic [PRIO_W-1:0] entry_priority,
	input logic [TAG_W-1:0]  entry_tag,
	input logic              out_valid,
	input logic              out_stall,
	input logic [TAG_W-1:0]  served_tag,
	input logic [PRIO_W-1:0] served_priority,
	input logic [1:0]        status,
	input logic [OCC_W-1:0]  occupancy
);

	// one item at a time: an accepted transaction blocks the next cycle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted on back-to-back cycles");

	// an empty pop only when nothing is held
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> (occupancy == '0))
		else $error("empty status with nonzero occupancy");

	// failed results carry no served entry
	a_no_served: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (served_tag == '0 && served_priority == '0))
		else $error("served fields set on a failed transaction");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(served_tag)
			&& $stable(status) && $stable(occupancy)))
		else $error("stalled output changed");

endmodule

bind five_level_stable_priority_queue flspq_checker u_flspq_checker (.*);
